/* sv/triangle_frustum_classify_core_assert.svh */
// Assertion macros shared by the triangle frustum classifier RTL.
`ifndef TRIANGLE_FRUSTUM_CLASSIFY_CORE_ASSERT_SVH
`define TRIANGLE_FRUSTUM_CLASSIFY_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the core clock, off while in reset.
`define TFC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("triangle_frustum_classify_core: same-cycle check failed");

// Next-cycle implication, sampled on the core clock, off while in reset.
`define TFC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("triangle_frustum_classify_core: next-cycle check failed");

`endif

/* sv/tfc_pkg.sv */
// Package with the constants, codes and types of the triangle frustum classifier.
`timescale 1ns / 1ps

package tfc_pkg;

    // Geometry of one word: four side planes, three vertices, three axes.
    localparam int PLANES  = 4;
    localparam int VERTS   = 3;
    localparam int AXES    = 3;

    // Field and register widths.
    localparam int COORD_W        = 32;
    localparam int COEF_W         = 32;
    localparam int FRAC_BITS      = 16;
    localparam int REG_W          = 2 * COEF_W;
    localparam int NREGS          = 2 * PLANES;
    localparam int REG_IDX_W      = $clog2(NREGS);
    localparam int BYTE_SH        = 3;
    localparam int ADDR_W         = REG_IDX_W + BYTE_SH;
    localparam int STAT_W         = 2;
    localparam int COORD_BITS_DEF = 32;

    // Parent status codes on the input word.
    localparam logic [STAT_W-1:0] PAR_UNKNOWN = 2'd0;
    localparam logic [STAT_W-1:0] PAR_OUTSIDE = 2'd1;
    localparam logic [STAT_W-1:0] PAR_PARTIAL = 2'd2;
    localparam logic [STAT_W-1:0] PAR_INSIDE  = 2'd3;

    // Result status codes on the output word.
    localparam logic [STAT_W-1:0] ST_OUTSIDE = 2'd0;
    localparam logic [STAT_W-1:0] ST_PARTIAL = 2'd1;
    localparam logic [STAT_W-1:0] ST_INSIDE  = 2'd2;

    // Load enables of the three lane pipeline stages.
    typedef struct packed {
        logic en_s1;
        logic en_s2;
        logic en_s3;
    } t_pipe_ctl;

endpackage

/* sv/triangle_frustum_classify_core.sv */
// Top level of the triangle frustum classifier: plane registers, pipeline and lanes.
`timescale 1ns / 1ps
`include "triangle_frustum_classify_core_assert.svh"

// The core classifies one triangle against the right, left, bottom and top
// planes of a view frustum and takes a new word every clock cycle unless a
// full pipeline is held by a stall on the output. Each word passes through four
// register stages: the three lane stages and the output status register.
// Four plane lanes, each with nine multipliers, work side by side, and their
// results are merged into the status word. A stall on the output only holds the
// stages behind it while they are full, so empty stages keep taking words. Plane
// registers are written over the APB port and should be changed only while the
// core is idle.
module triangle_frustum_classify_core import tfc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [REG_W-1:0]   pwdata,
    output logic [REG_W-1:0]   prdata,
    output logic               pready,
    // Input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [STAT_W-1:0]  i_parent_status,
    input  logic [COORD_W-1:0] i_apex_x,
    input  logic [COORD_W-1:0] i_apex_y,
    input  logic [COORD_W-1:0] i_apex_z,
    input  logic [COORD_W-1:0] i_left_x,
    input  logic [COORD_W-1:0] i_left_y,
    input  logic [COORD_W-1:0] i_left_z,
    input  logic [COORD_W-1:0] i_right_x,
    input  logic [COORD_W-1:0] i_right_y,
    input  logic [COORD_W-1:0] i_right_z,
    // Output channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [STAT_W-1:0]  o_status
);

    logic [REG_W-1:0]            r_plane [NREGS];
    logic [COORD_BITS-1:0]       w_vtx [VERTS][AXES];
    t_pipe_ctl                   w_ctl;
    logic                        w_en_out;
    logic                        r_v1;
    logic                        r_v2;
    logic                        r_v3;
    logic                        r_out_valid;
    logic [STAT_W-1:0]           r_par1;
    logic [STAT_W-1:0]           r_par2;
    logic [STAT_W-1:0]           r_par3;
    logic [STAT_W-1:0]           r_status;
    logic [STAT_W-1:0]           w_status;
    logic [PLANES-1:0][VERTS-1:0] w_front;

    // Plane registers, written at the access phase of an APB write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NREGS; i++) begin
                r_plane[i] <= '0;
            end
        end else if (psel && penable && pwrite) begin
            r_plane[paddr[ADDR_W-1:BYTE_SH]] <= pwdata;
        end
    end

    assign prdata = r_plane[paddr[ADDR_W-1:BYTE_SH]];
    assign pready = 1'b1;

    // Only the low coordinate bits are used; the lanes sign-extend them.
    assign w_vtx[0][0] = i_apex_x[COORD_BITS-1:0];
    assign w_vtx[0][1] = i_apex_y[COORD_BITS-1:0];
    assign w_vtx[0][2] = i_apex_z[COORD_BITS-1:0];
    assign w_vtx[1][0] = i_left_x[COORD_BITS-1:0];
    assign w_vtx[1][1] = i_left_y[COORD_BITS-1:0];
    assign w_vtx[1][2] = i_left_z[COORD_BITS-1:0];
    assign w_vtx[2][0] = i_right_x[COORD_BITS-1:0];
    assign w_vtx[2][1] = i_right_y[COORD_BITS-1:0];
    assign w_vtx[2][2] = i_right_z[COORD_BITS-1:0];

    // A stage loads when it is empty or when the stage after it moves on.
    assign w_en_out     = !r_out_valid || i_out_ready;
    assign w_ctl.en_s3  = !r_v3 || w_en_out;
    assign w_ctl.en_s2  = !r_v2 || w_ctl.en_s3;
    assign w_ctl.en_s1  = !r_v1 || w_ctl.en_s2;
    assign o_in_ready   = w_ctl.en_s1;

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_ctl.en_s1) begin
                r_v1 <= i_in_valid;
            end
            if (w_ctl.en_s2) begin
                r_v2 <= r_v1;
            end
            if (w_ctl.en_s3) begin
                r_v3 <= r_v2;
            end
            if (w_en_out) begin
                r_out_valid <= r_v3;
            end
        end
    end

    // Parent status travels alongside the lane stages; the result is registered.
    always_ff @(posedge i_clk) begin
        if (w_ctl.en_s1) begin
            r_par1 <= i_parent_status;
        end
        if (w_ctl.en_s2) begin
            r_par2 <= r_par1;
        end
        if (w_ctl.en_s3) begin
            r_par3 <= r_par2;
        end
        if (w_en_out) begin
            r_status <= w_status;
        end
    end

    // One lane per side plane.
    for (genvar p = 0; p < PLANES; p++) begin : g_lane
        tfc_plane_lane #(
            .COORD_BITS (COORD_BITS)
        ) u_lane (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_plane_ab (r_plane[2*p]),
            .i_plane_cd (r_plane[2*p+1]),
            .i_vtx      (w_vtx),
            .o_front    (w_front[p])
        );
    end

    tfc_merge u_merge (
        .i_parent_status (r_par3),
        .i_front         (w_front),
        .o_status        (w_status)
    );

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;

    // An accepted word always occupies the first stage on the next cycle.
    `TFC_ASSERT_NEXT(a_accept_fills_s1, i_in_valid && o_in_ready, r_v1)
    // A stalled first stage keeps its word and its parent status.
    `TFC_ASSERT_NEXT(a_s1_holds, !w_ctl.en_s1, r_v1 && $stable(r_par1))
    // A completely inside parent yields a completely inside result.
    `TFC_ASSERT_NEXT(a_inside_passes, r_v3 && (r_par3 == PAR_INSIDE) && w_en_out,
        r_out_valid && (r_status == ST_INSIDE))
    // With the output register empty the core always takes a word.
    `TFC_ASSERT_SAME(a_ready_when_empty, !r_out_valid, o_in_ready)

endmodule

/* sv/tfc_plane_lane.sv */
// One plane lane: tests the three vertices of a triangle against one plane.
`timescale 1ns / 1ps

module tfc_plane_lane import tfc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  t_pipe_ctl             i_ctl,
    input  logic [REG_W-1:0]      i_plane_ab,
    input  logic [REG_W-1:0]      i_plane_cd,
    input  logic [COORD_BITS-1:0] i_vtx [VERTS][AXES],
    output logic [VERTS-1:0]      o_front
);

    localparam int PROD_W = COEF_W + COORD_BITS;
    localparam int SUM1_W = PROD_W + 1;
    localparam int SUM2_W = PROD_W + 2;
    localparam int DSH_W  = COEF_W + FRAC_BITS;

    logic signed [COEF_W-1:0] w_coef [AXES];
    logic signed [COEF_W-1:0] w_d;
    logic signed [PROD_W-1:0] r_prod [VERTS][AXES];
    logic signed [COEF_W-1:0] r_d1;
    logic signed [DSH_W-1:0]  w_dsh;
    logic signed [SUM1_W-1:0] r_sab [VERTS];
    logic signed [SUM1_W-1:0] r_scd [VERTS];
    logic signed [SUM2_W-1:0] w_tot [VERTS];
    logic [VERTS-1:0]         r_front;

    // Split the two registers into the coefficients a, b, c and d.
    assign w_coef[0] = i_plane_ab[REG_W-1:COEF_W];
    assign w_coef[1] = i_plane_ab[COEF_W-1:0];
    assign w_coef[2] = i_plane_cd[REG_W-1:COEF_W];
    assign w_d       = i_plane_cd[COEF_W-1:0];

    // Stage one: the nine coefficient by coordinate products.
    always_ff @(posedge i_clk) begin
        if (i_ctl.en_s1) begin
            for (int v = 0; v < VERTS; v++) begin
                for (int k = 0; k < AXES; k++) begin
                    r_prod[v][k] <= w_coef[k] * $signed(i_vtx[v][k]);
                end
            end
            r_d1 <= w_d;
        end
    end

    // The offset d is brought up to the product scale.
    assign w_dsh = $signed({r_d1, {FRAC_BITS{1'b0}}});

    // Stage two: pairwise sums, a*x + b*y and c*z + d.
    always_ff @(posedge i_clk) begin
        if (i_ctl.en_s2) begin
            for (int v = 0; v < VERTS; v++) begin
                r_sab[v] <= SUM1_W'(r_prod[v][0]) + SUM1_W'(r_prod[v][1]);
                r_scd[v] <= SUM1_W'(r_prod[v][2]) + SUM1_W'(w_dsh);
            end
        end
    end

    // Final exact sum per vertex.
    always_comb begin
        for (int v = 0; v < VERTS; v++) begin
            w_tot[v] = SUM2_W'(r_sab[v]) + SUM2_W'(r_scd[v]);
        end
    end

    // Stage three: a vertex is in front when the plane value is strictly positive.
    always_ff @(posedge i_clk) begin
        if (i_ctl.en_s3) begin
            for (int v = 0; v < VERTS; v++) begin
                r_front[v] <= !w_tot[v][SUM2_W-1] && (w_tot[v] != '0);
            end
        end
    end

    assign o_front = r_front;

endmodule

/* sv/tfc_merge.sv */
// Merging stage: combines the per-plane vertex tests and the parent status.
`timescale 1ns / 1ps

module tfc_merge import tfc_pkg::*; (
    input  logic [STAT_W-1:0]            i_parent_status,
    input  logic [PLANES-1:0][VERTS-1:0] i_front,
    output logic [STAT_W-1:0]            o_status
);

    logic w_any_behind;
    logic w_all_front;

    // A plane with no vertex in front culls the triangle; all in front on
    // every plane means it lies completely inside.
    always_comb begin
        w_any_behind = 1'b0;
        w_all_front  = 1'b1;
        for (int p = 0; p < PLANES; p++) begin
            w_any_behind = w_any_behind | (i_front[p] == '0);
            w_all_front  = w_all_front & (&i_front[p]);
        end
    end

    // A parent that is outside or completely inside passes its status on.
    always_comb begin
        case (i_parent_status)
            PAR_INSIDE: begin
                o_status = ST_INSIDE;
            end
            PAR_OUTSIDE: begin
                o_status = ST_OUTSIDE;
            end
            default: begin
                if (w_any_behind) begin
                    o_status = ST_OUTSIDE;
                end else if (w_all_front) begin
                    o_status = ST_INSIDE;
                end else begin
                    o_status = ST_PARTIAL;
                end
            end
        endcase
    end

endmodule

/* test/testbench.sv */
// Self-checking testbench for the triangle frustum classifier core.
`timescale 1ns / 1ps

module testbench;
    import tfc_pkg::*;

    localparam int COORD_BITS   = COORD_BITS_DEF;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_WORDS  = 192;
    localparam logic [COEF_W-1:0] Q_ONE = 32'h0001_0000;
    localparam logic [COEF_W-1:0] C_MIN = 32'h8000_0000;
    localparam logic [COEF_W-1:0] C_MAX = 32'h7FFF_FFFF;

    typedef enum int {
        PLANES_ZERO,
        PLANES_ALL_MIN,
        PLANES_BOX,
        PLANES_VIEW,
        PLANES_RANDOM,
        PLANES_EXTREME
    } plane_set_e;

    // One input word: parent status and nine coordinates, apex first, x y z per vertex.
    typedef struct packed {
        logic [STAT_W-1:0]                  parent;
        logic [VERTS*AXES-1:0][COORD_W-1:0] coord;
    } tri_word_t;

    // Scoreboard: predicts the status of each accepted triangle and checks the results in order.
    class cull_scoreboard #(int CB = 32);
        logic [REG_W-1:0]  plane_regs [NREGS];
        logic [STAT_W-1:0] pending_status [$];
        int                errors;
        int                triangles;
        int                tally [3];

        function new();
            foreach (plane_regs[i]) plane_regs[i] = '0;
            foreach (tally[i]) tally[i] = 0;
            errors    = 0;
            triangles = 0;
        endfunction

        // Only the low CB bits of a coordinate count, sign-extended.
        function logic signed [COORD_W-1:0] widen(logic [COORD_W-1:0] raw);
            logic signed [COORD_W-1:0] t;
            t = $signed(raw) <<< (COORD_W - CB);
            return t >>> (COORD_W - CB);
        endfunction

        // Exact plane value a*x + b*y + c*z + d*2^16; zero does not count as in front.
        function bit ahead_of(int p, input logic signed [COORD_W-1:0] x, y, z);
            logic signed [79:0] ka, kb, kc, kd, acc;
            ka  = $signed(plane_regs[2*p][REG_W-1:COEF_W]);
            kb  = $signed(plane_regs[2*p][COEF_W-1:0]);
            kc  = $signed(plane_regs[2*p+1][REG_W-1:COEF_W]);
            kd  = $signed(plane_regs[2*p+1][COEF_W-1:0]);
            acc = ka * x + kb * y + kc * z + (kd <<< FRAC_BITS);
            return acc > 0;
        endfunction

        function logic [STAT_W-1:0] classify_triangle(tri_word_t w);
            logic signed [COORD_W-1:0] c [VERTS*AXES];
            int ahead;
            int full;
            foreach (c[k]) c[k] = widen(w.coord[k]);
            if (w.parent == PAR_INSIDE) return ST_INSIDE;
            if (w.parent == PAR_OUTSIDE) return ST_OUTSIDE;
            full = 0;
            for (int p = 0; p < PLANES; p++) begin
                ahead = 0;
                for (int v = 0; v < VERTS; v++)
                    if (ahead_of(p, c[AXES*v], c[AXES*v+1], c[AXES*v+2])) ahead++;
                if (ahead == 0) return ST_OUTSIDE;
                if (ahead == VERTS) full++;
            end
            return (full == PLANES) ? ST_INSIDE : ST_PARTIAL;
        endfunction

        function void note_triangle(tri_word_t w);
            logic [STAT_W-1:0] s;
            s = classify_triangle(w);
            pending_status.push_back(s);
            tally[s]++;
            triangles++;
        endfunction

        function void check_status(logic [STAT_W-1:0] got);
            logic [STAT_W-1:0] want;
            if (pending_status.size() == 0) begin
                $error("o_status word %0d arrived with nothing expected", got);
                errors++;
                return;
            end
            want = pending_status.pop_front();
            if (got !== want) begin
                $error("field status mismatch: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [REG_W-1:0]   pwdata;
    logic [REG_W-1:0]   prdata;
    logic               pready;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [STAT_W-1:0]  i_parent_status;
    logic [COORD_W-1:0] i_apex_x, i_apex_y, i_apex_z;
    logic [COORD_W-1:0] i_left_x, i_left_y, i_left_z;
    logic [COORD_W-1:0] i_right_x, i_right_y, i_right_z;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [STAT_W-1:0]  o_status;

    cull_scoreboard #(COORD_BITS) sb;
    int          cycle_count   = 0;
    int          planes_loaded = 0;
    int          source_mode   = 0;
    int          sink_mode     = 0;
    int          stall_left    = 0;
    int unsigned spread        = Q_ONE;
    bit          view_mode     = 1'b0;

    triangle_frustum_classify_core #(.COORD_BITS(COORD_BITS)) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_parent_status(i_parent_status),
        .i_apex_x       (i_apex_x),
        .i_apex_y       (i_apex_y),
        .i_apex_z       (i_apex_z),
        .i_left_x       (i_left_x),
        .i_left_y       (i_left_y),
        .i_left_z       (i_left_z),
        .i_right_x      (i_right_x),
        .i_right_y      (i_right_y),
        .i_right_z      (i_right_z),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status)
    );

    // Clock with an 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Both handshakes are sampled at the clock edge that completes them.
    always @(posedge i_clk) begin
        tri_word_t taken;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                taken.parent   = i_parent_status;
                taken.coord[0] = i_apex_x;
                taken.coord[1] = i_apex_y;
                taken.coord[2] = i_apex_z;
                taken.coord[3] = i_left_x;
                taken.coord[4] = i_left_y;
                taken.coord[5] = i_left_z;
                taken.coord[6] = i_right_x;
                taken.coord[7] = i_right_y;
                taken.coord[8] = i_right_z;
                sb.note_triangle(taken);
            end
            if (o_out_valid && i_out_ready) sb.check_status(o_status);
        end
    end

    // Output back-pressure: always ready, light or heavy random stalls, or rare long stalls.
    always @(posedge i_clk) begin
        case (sink_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= ($urandom_range(0, 3) != 0);
            2: i_out_ready <= ($urandom_range(0, 3) == 0);
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    i_out_ready <= 1'b0;
                end else if ($urandom_range(0, 39) == 0) begin
                    stall_left = $urandom_range(8, 60);
                    i_out_ready <= 1'b0;
                end else begin
                    i_out_ready <= 1'b1;
                end
            end
        endcase
    end

    // Gap before the next input word, mostly short with the odd long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        case (source_mode)
            0: return 0;
            1: return (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 30);
            default: return (r < 30) ? 0 : (r < 85) ? $urandom_range(1, 4) : $urandom_range(5, 40);
        endcase
    endfunction

    function automatic logic [STAT_W-1:0] pick_parent();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return PAR_UNKNOWN;
        if (r < 80) return PAR_PARTIAL;
        if (r < 90) return PAR_OUTSIDE;
        return PAR_INSIDE;
    endfunction

    function automatic logic [COORD_W-1:0] pick_extreme();
        case ($urandom_range(0, 5))
            0: return C_MIN;
            1: return C_MAX;
            2: return '0;
            3: return '1;
            4: return 32'd1;
            default: return Q_ONE;
        endcase
    endfunction

    // Values on or next to the planes of a box or view set, where the plane value is zero.
    function automatic logic [COORD_W-1:0] pick_boundary();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return spread;
            2: return -spread;
            default: return spread + $urandom_range(0, 2) - 1;
        endcase
    endfunction

    // Mostly small triangles clustered around a point near the frustum, the rest noise.
    function automatic tri_word_t random_triangle();
        tri_word_t        w;
        logic [COORD_W-1:0] mid [AXES];
        int unsigned      jit;
        int               r;
        w.parent = pick_parent();
        r        = $urandom_range(0, 99);
        jit      = spread / 2 + 1;
        for (int a = 0; a < AXES; a++) mid[a] = $urandom_range(0, 4 * spread) - 2 * spread;
        if (view_mode) mid[2] = $urandom_range(0, 2 * spread);
        for (int k = 0; k < VERTS * AXES; k++) begin
            if (r < 70)
                w.coord[k] = mid[k % AXES] + $urandom_range(0, 2 * jit) - jit;
            else if (r < 85)
                w.coord[k] = $urandom_range(0, 1) ? pick_boundary()
                                                  : mid[k % AXES] + $urandom_range(0, jit);
            else if (r < 93)
                w.coord[k] = $urandom;
            else
                w.coord[k] = pick_extreme();
        end
        return w;
    endfunction

    task automatic shuffle_pace();
        source_mode = $urandom_range(0, 2);
        sink_mode   = $urandom_range(0, 3);
    endtask

    // Present one word and hold it until the core takes it.
    task automatic send_triangle(tri_word_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_parent_status <= w.parent;
        i_apex_x        <= w.coord[0];
        i_apex_y        <= w.coord[1];
        i_apex_z        <= w.coord[2];
        i_left_x        <= w.coord[3];
        i_left_y        <= w.coord[4];
        i_left_z        <= w.coord[5];
        i_right_x       <= w.coord[6];
        i_right_y       <= w.coord[7];
        i_right_z       <= w.coord[8];
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_vertices(logic [STAT_W-1:0] parent,
                                 logic [COORD_W-1:0] ax, ay, az, lx, ly, lz, rx, ry, rz);
        tri_word_t w;
        w.parent = parent;
        w.coord  = {rz, ry, rx, lz, ly, lx, az, ay, ax};
        send_triangle(w);
    endtask

    task automatic send_uniform(logic [STAT_W-1:0] parent, logic [COORD_W-1:0] v);
        send_vertices(parent, v, v, v, v, v, v, v, v, v);
    endtask

    // Let every expected status come back, then give the pipeline time to empty.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.pending_status.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready. The caller ends the transfer.
    task automatic apb_write(int idx, logic [REG_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << BYTE_SH;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.plane_regs[idx] = val;
    endtask

    // Write all eight plane registers. Order: right, left, bottom, top; ab then cd.
    task automatic load_planes(plane_set_e kind, int unsigned reach);
        logic [REG_W-1:0]  regs [NREGS];
        logic [COEF_W-1:0] slope, d;
        spread    = reach;
        view_mode = (kind == PLANES_VIEW);
        case (kind)
            PLANES_ZERO: begin
                foreach (regs[i]) regs[i] = '0;
            end
            PLANES_ALL_MIN: begin
                foreach (regs[i]) regs[i] = {C_MIN, C_MIN};
            end
            PLANES_BOX: begin
                // Axis-aligned box |x| < reach, |y| < reach.
                regs[0] = {-Q_ONE, 32'h0};
                regs[1] = {32'h0, reach};
                regs[2] = {Q_ONE, 32'h0};
                regs[3] = {32'h0, reach};
                regs[4] = {32'h0, Q_ONE};
                regs[5] = {32'h0, reach};
                regs[6] = {32'h0, -Q_ONE};
                regs[7] = {32'h0, reach};
            end
            PLANES_VIEW: begin
                // Pyramid opening along +z with a random slope and a small offset.
                slope   = $urandom_range(Q_ONE / 4, 4 * Q_ONE);
                d       = $urandom_range(0, Q_ONE);
                regs[0] = {-Q_ONE, 32'h0};
                regs[1] = {slope, d};
                regs[2] = {Q_ONE, 32'h0};
                regs[3] = {slope, d};
                regs[4] = {32'h0, Q_ONE};
                regs[5] = {slope, d};
                regs[6] = {32'h0, -Q_ONE};
                regs[7] = {slope, d};
            end
            PLANES_RANDOM: begin
                foreach (regs[i]) regs[i] = {$urandom, $urandom};
            end
            default: begin
                foreach (regs[i]) regs[i] = {pick_extreme(), pick_extreme()};
            end
        endcase
        for (int i = 0; i < NREGS; i++) apb_write(i, regs[i]);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        planes_loaded++;
    endtask

    initial begin
        plane_set_e phase_planes [6];
        phase_planes = '{PLANES_BOX, PLANES_VIEW, PLANES_RANDOM,
                         PLANES_BOX, PLANES_EXTREME, PLANES_VIEW};
        sb = new();

        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        i_in_valid      <= 1'b0;
        i_parent_status <= '0;
        i_apex_x        <= '0;
        i_apex_y        <= '0;
        i_apex_z        <= '0;
        i_left_x        <= '0;
        i_left_y        <= '0;
        i_left_z        <= '0;
        i_right_x       <= '0;
        i_right_y       <= '0;
        i_right_z       <= '0;
        i_out_ready     <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Planes still at reset: nothing is in front, so only the parent can force inside.
        shuffle_pace();
        send_uniform(PAR_UNKNOWN, '0);
        send_uniform(PAR_PARTIAL, C_MAX);
        send_uniform(PAR_OUTSIDE, C_MIN);
        send_uniform(PAR_INSIDE, C_MIN);
        wait_idle();

        // Largest negative coefficients against extreme vertices: sums overflow 64 bits.
        load_planes(PLANES_ALL_MIN, Q_ONE);
        shuffle_pace();
        send_uniform(PAR_UNKNOWN, C_MIN);
        send_uniform(PAR_PARTIAL, C_MAX);
        send_vertices(PAR_UNKNOWN, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
        send_uniform(PAR_INSIDE, C_MAX);
        send_vertices(PAR_PARTIAL, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                      32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, '1, 32'd1, '0);
        wait_idle();

        // Unit box: vertices on a plane give a value of exactly zero.
        load_planes(PLANES_BOX, Q_ONE);
        shuffle_pace();
        send_uniform(PAR_UNKNOWN, '0);
        send_vertices(PAR_UNKNOWN, Q_ONE, '0, '0, '0, '0, '0, '0, '0, '0);
        send_vertices(PAR_PARTIAL, Q_ONE, '0, '0, Q_ONE, '0, '0, Q_ONE, '0, '0);
        send_uniform(PAR_PARTIAL, 2 * Q_ONE);
        send_uniform(PAR_OUTSIDE, '0);
        send_uniform(PAR_INSIDE, 3 * Q_ONE);
        send_vertices(PAR_UNKNOWN, '0, '0, '0, 3 * Q_ONE, '0, '0, '0, -3 * Q_ONE, '0);
        send_vertices(PAR_PARTIAL, Q_ONE / 2, Q_ONE / 2, C_MAX, -Q_ONE / 2, '0, C_MIN,
                      '0, -Q_ONE / 2, '1);

        // Random triangles over a series of plane sets, with the pace changing as it goes.
        foreach (phase_planes[ph]) begin
            wait_idle();
            load_planes(phase_planes[ph], $urandom_range(Q_ONE / 8, 1000 * Q_ONE));
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (n % 48 == 0) shuffle_pace();
                send_triangle(random_triangle());
            end
        end
        wait_idle();

        $display("Checked %0d triangles under %0d plane settings with random gaps and stalls.",
                 sb.triangles, planes_loaded);
        $display("Predicted outside %0d, partially inside %0d, completely inside %0d.",
                 sb.tally[ST_OUTSIDE], sb.tally[ST_PARTIAL], sb.tally[ST_INSIDE]);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
